FILE: hdl/stt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stt_pkg - shared types and constants of the software timer table
// Entry layout, controller states, result kind codes and table sizing.
// ---------------------------------------------------------------------------
package stt_pkg;

    // table sizing
    localparam int NUM_TIMERS = 16;
    localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int MAX_OUT    = 16;
    localparam int FCNT_W     = $clog2(MAX_OUT + 1);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_TIMERS - 1);
    localparam logic [FCNT_W-1:0] FCNT_MAX  = FCNT_W'(MAX_OUT);

    localparam logic [15:0] TICK_PERIOD_RST = 16'd200;

    // result kinds
    localparam logic [1:0] KIND_REG   = 2'd0;
    localparam logic [1:0] KIND_FIRE  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // input actions
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_REG  = 1'b1;

    // one timer entry as it travels along the chain
    typedef struct packed {
        logic        valid;
        logic [31:0] remaining;
        logic [31:0] reload;
        logic        rpt;
        logic [7:0]  tag;
    } entry_t;

    // serial modulo unit status
    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } div_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WALK,
        ST_FINISH
    } state_t;

    // slot number masked to the 4-bit result field
    function automatic logic [3:0] slot_field(input logic [SLOT_W-1:0] s);
        logic [31:0] w;
        w = 32'(s);
        return w[3:0];
    endfunction

endpackage

FILE: hdl/stt_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stt_cell - one link of the timer chain
// Holds one timer entry and takes its neighbor's entry on every shift.
// ---------------------------------------------------------------------------
module stt_cell
    import stt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift_en,
    input  entry_t ent_in,
    output entry_t ent_q
);

    logic        valid_reg, valid_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [31:0] reload_reg, reload_next;
    logic        rpt_reg, rpt_next;
    logic [7:0]  tag_reg, tag_next;

    // take neighbor entry on shift, else hold
    always_comb
    begin
        valid_next     = valid_reg;
        remaining_next = remaining_reg;
        reload_next    = reload_reg;
        rpt_next       = rpt_reg;
        tag_next       = tag_reg;
        if (shift_en)
        begin
            valid_next     = ent_in.valid;
            remaining_next = ent_in.remaining;
            reload_next    = ent_in.reload;
            rpt_next       = ent_in.rpt;
            tag_next       = ent_in.tag;
        end
    end

    // valid bit is control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        remaining_reg <= remaining_next;
        reload_reg    <= reload_next;
        rpt_reg       <= rpt_next;
        tag_reg       <= tag_next;
    end

    assign ent_q.valid     = valid_reg;
    assign ent_q.remaining = remaining_reg;
    assign ent_q.reload    = reload_reg;
    assign ent_q.rpt       = rpt_reg;
    assign ent_q.tag       = tag_reg;

endmodule

FILE: hdl/stt_head.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stt_head - update logic at the head of the chain
// Counts down the entry leaving cell 0 on a tick, or drops a new timer into
// the first free entry on a register walk.
// ---------------------------------------------------------------------------
module stt_head
    import stt_pkg::*;
(
    input  entry_t      ent_in,
    input  logic        reg_mode,
    input  logic        reg_take,
    input  logic [31:0] new_period,
    input  logic        new_rpt,
    input  logic [7:0]  new_tag,
    input  logic [15:0] tick_period,
    output entry_t      ent_out,
    output logic        fire,
    output logic        insert
);

    logic [31:0] tp_ext;

    assign tp_ext = {16'd0, tick_period};

    always_comb
    begin
        ent_out = ent_in;
        fire    = 1'b0;
        insert  = 1'b0;
        if (reg_mode)
        begin
            // register: claim first free entry
            if (reg_take && !ent_in.valid)
            begin
                insert            = 1'b1;
                ent_out.valid     = 1'b1;
                ent_out.remaining = new_period;
                ent_out.reload    = new_period;
                ent_out.rpt       = new_rpt;
                ent_out.tag       = new_tag;
            end
        end
        else if (ent_in.valid)
        begin
            // tick: saturating countdown, fire at zero
            if (ent_in.remaining > tp_ext)
                ent_out.remaining = ent_in.remaining - tp_ext;
            else if (tick_period != 16'd0)
            begin
                fire              = 1'b1;
                ent_out.remaining = ent_in.rpt ? ent_in.reload : 32'd0;
                ent_out.valid     = ent_in.rpt;
            end
        end
    end

endmodule

FILE: hdl/stt_moddiv.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stt_moddiv - serial modulo check
// Restoring division of a 32-bit period by the 16-bit tick, one bit per
// cycle; reports whether the remainder is zero.
// ---------------------------------------------------------------------------
module stt_moddiv
    import stt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output div_stat_t   stat
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [31:0] shf_reg, shf_next;
    logic [16:0] trial;
    logic [16:0] diff;

    assign trial = {rem_reg, shf_reg[31]};
    assign diff  = trial - {1'b0, divisor};

    // one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            rem_next  = 16'd0;
            shf_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = (trial >= {1'b0, divisor}) ? diff[15:0] : trial[15:0];
            shf_next = {shf_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.rem_zero = (rem_reg == 16'd0);

endmodule

FILE: hdl/software_timer_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// software_timer_table - table of software timers driven by a base tick
// Timer entries live in a ring of cells that rotates through one update
// head; registrations are screened by a serial modulo unit.
// ---------------------------------------------------------------------------
// One item at a time. A tick rotates all NUM_TIMERS entries once through the
// head, one entry per cycle while the result side does not stall the walk;
// firings come out in slot order, the last flagged with last. A register item
// first runs the 32-step modulo check of the period against tick_period, then
// rotates the ring to claim the lowest free slot when the period passes the
// check, even if the table turns out full, and goes straight to its result
// when it fails. in_stall stays high while an item is in work. The user
// writes tick_period through cfg_write/cfg_data only while the block is
// idle; the block itself does not enforce this.
module software_timer_table
    import stt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [31:0] period_ms,
    input  logic        repeat_mode,
    input  logic [7:0]  callback_tag,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic        accepted,
    output logic [3:0]  slot,
    output logic [7:0]  fired_tag,
    output logic        last
);

    state_t state_reg, state_next;

    logic [15:0]       tick_period_reg, tick_period_next;
    logic              act_reg, act_next;
    logic [31:0]       period_reg, period_next;
    logic              rpt_reg, rpt_next;
    logic [7:0]        tag_reg, tag_next;
    logic              ok_reg, ok_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] found_slot_reg, found_slot_next;
    logic [SLOT_W-1:0] step_reg, step_next;
    logic [FCNT_W-1:0] fcnt_reg, fcnt_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;
    logic [7:0]        pend_tag_reg, pend_tag_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        kind_reg, kind_next;
    logic              accepted_reg, accepted_next;
    logic [3:0]        slot_reg, slot_next;
    logic [7:0]        fired_tag_reg, fired_tag_next;
    logic              last_reg, last_next;

    logic              in_take;
    logic              out_free;
    logic              div_start;
    div_stat_t         div_stat;
    logic              shift_en;
    logic              step_go;
    logic              head_fire;
    logic              head_insert;
    logic              fire_report;
    entry_t            head_out;
    entry_t            cell_q [NUM_TIMERS];

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // serial modulo check of the requested period
    stt_moddiv u_moddiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (period_reg),
        .divisor  (tick_period_reg),
        .stat     (div_stat)
    );

    // head update on the entry leaving cell 0
    stt_head u_head (
        .ent_in      (cell_q[0]),
        .reg_mode    (act_reg),
        .reg_take    (ok_reg && !found_reg),
        .new_period  (period_reg),
        .new_rpt     (rpt_reg),
        .new_tag     (tag_reg),
        .tick_period (tick_period_reg),
        .ent_out     (head_out),
        .fire        (head_fire),
        .insert      (head_insert)
    );

    // ring of cells, head feeds the tail
    for (genvar i = 0; i < NUM_TIMERS; i++)
    begin : g_cell
        entry_t nb;
        if (i == NUM_TIMERS - 1)
        begin : g_tail
            assign nb = head_out;
        end
        else
        begin : g_mid
            assign nb = cell_q[i+1];
        end
        stt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .ent_in   (nb),
            .ent_q    (cell_q[i])
        );
    end

    // a reported firing with a result already pending needs the output slot
    assign fire_report = head_fire && (fcnt_reg < FCNT_MAX);
    assign step_go     = !(fire_report && pend_valid_reg && !out_free);
    assign shift_en    = (state_reg == ST_WALK) && step_go;

    // controller: next state and outputs
    always_comb
    begin
        state_next       = state_reg;
        tick_period_next = cfg_write ? cfg_data : tick_period_reg;
        act_next         = act_reg;
        period_next      = period_reg;
        rpt_next         = rpt_reg;
        tag_next         = tag_reg;
        ok_next          = ok_reg;
        found_next       = found_reg;
        found_slot_next  = found_slot_reg;
        step_next        = step_reg;
        fcnt_next        = fcnt_reg;
        pend_valid_next  = pend_valid_reg;
        pend_slot_next   = pend_slot_reg;
        pend_tag_next    = pend_tag_reg;
        div_start        = 1'b0;

        out_valid_next   = out_valid_reg && out_stall;
        kind_next        = kind_reg;
        accepted_next    = accepted_reg;
        slot_next        = slot_reg;
        fired_tag_next   = fired_tag_reg;
        last_next        = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    act_next        = action;
                    period_next     = period_ms;
                    rpt_next        = repeat_mode;
                    tag_next        = callback_tag;
                    ok_next         = 1'b0;
                    found_next      = 1'b0;
                    found_slot_next = '0;
                    step_next       = '0;
                    fcnt_next       = '0;
                    pend_valid_next = 1'b0;
                    state_next      = (action == ACT_REG) ? ST_DIV : ST_WALK;
                end
            end
            ST_DIV:
            begin
                div_start = !div_stat.busy && !div_stat.done;
                if (div_stat.done)
                begin
                    ok_next    = (period_reg != 32'd0) && (tick_period_reg != 16'd0)
                                 && div_stat.rem_zero;
                    state_next = ((period_reg != 32'd0) && (tick_period_reg != 16'd0)
                                 && div_stat.rem_zero) ? ST_WALK : ST_FINISH;
                end
            end
            ST_WALK:
            begin
                if (step_go)
                begin
                    if (head_insert)
                    begin
                        found_next      = 1'b1;
                        found_slot_next = step_reg;
                    end
                    if (fire_report)
                    begin
                        fcnt_next = fcnt_reg + FCNT_W'(1);
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_FIRE;
                            accepted_next  = 1'b0;
                            slot_next      = slot_field(pend_slot_reg);
                            fired_tag_next = pend_tag_reg;
                            last_next      = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = step_reg;
                        pend_tag_next   = cell_q[0].tag;
                    end
                    step_next = step_reg + SLOT_W'(1);
                    if (step_reg == LAST_SLOT)
                        state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    if (act_reg == ACT_REG)
                    begin
                        kind_next      = KIND_REG;
                        accepted_next  = found_reg;
                        slot_next      = found_reg ? slot_field(found_slot_reg) : 4'd0;
                        fired_tag_next = 8'd0;
                    end
                    else if (pend_valid_reg)
                    begin
                        kind_next      = KIND_FIRE;
                        accepted_next  = 1'b0;
                        slot_next      = slot_field(pend_slot_reg);
                        fired_tag_next = pend_tag_reg;
                    end
                    else
                    begin
                        kind_next      = KIND_EMPTY;
                        accepted_next  = 1'b0;
                        slot_next      = 4'd0;
                        fired_tag_next = 8'd0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            tick_period_reg <= TICK_PERIOD_RST;
            ok_reg          <= 1'b0;
            found_reg       <= 1'b0;
            step_reg        <= '0;
            fcnt_reg        <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            tick_period_reg <= tick_period_next;
            ok_reg          <= ok_next;
            found_reg       <= found_next;
            step_reg        <= step_next;
            fcnt_reg        <= fcnt_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        period_reg     <= period_next;
        rpt_reg        <= rpt_next;
        tag_reg        <= tag_next;
        found_slot_reg <= found_slot_next;
        pend_slot_reg  <= pend_slot_next;
        pend_tag_reg   <= pend_tag_next;
        kind_reg       <= kind_next;
        accepted_reg   <= accepted_next;
        slot_reg       <= slot_next;
        fired_tag_reg  <= fired_tag_next;
        last_reg       <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign accepted  = accepted_reg;
    assign slot      = slot_reg;
    assign fired_tag = fired_tag_reg;
    assign last      = last_reg;

    // checks
    a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= FCNT_MAX)
        else $error("firing count beyond limit");

    a_take_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_stall)
        else $error("second beat taken while busy");

    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) && step_go && (step_reg == LAST_SLOT)
        |=> state_reg == ST_FINISH)
        else $error("walk did not end after last slot");

    a_pend_tick: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && (state_reg != ST_IDLE) |-> act_reg == ACT_TICK)
        else $error("pending firing during register");

endmodule

FILE: test/stt_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stt_checker - result predictor and scoreboard for the software timer table
// Mirrors the timer table from the accepted input beats and the tick_period
// writes, queues the results each beat should cause and compares every
// accepted result beat field by field against the oldest queued one.
// ---------------------------------------------------------------------------
module stt_checker
    import stt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        action,
    input  logic [31:0] period_ms,
    input  logic        repeat_mode,
    input  logic [7:0]  callback_tag,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  kind,
    input  logic        accepted,
    input  logic [3:0]  slot,
    input  logic [7:0]  fired_tag,
    input  logic        last,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [1:0] kind;
        logic       accepted;
        logic [3:0] slot;
        logic [7:0] tag;
        logic       last;
    } timer_result_t;

    // mirrored table and tick length
    logic [15:0] tick_len;
    logic        live       [NUM_TIMERS];
    logic [31:0] count_ms   [NUM_TIMERS];
    logic [31:0] reload_val [NUM_TIMERS];
    logic        repeats    [NUM_TIMERS];
    logic [7:0]  tags       [NUM_TIMERS];

    timer_result_t expected_results[$];
    int            errors = 0;

    assign fail_count = errors;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    // append one expected result at the tail of the queue
    task automatic queue_result(input timer_result_t r);
        expected_results.insert(expected_results.size(), r);
    endtask

    function automatic timer_result_t make_result(input logic [1:0] k, input logic acc,
                                                  input logic [3:0] s, input logic [7:0] t,
                                                  input logic l);
        timer_result_t r;
        r.kind     = k;
        r.accepted = acc;
        r.slot     = s;
        r.tag      = t;
        r.last     = l;
        return r;
    endfunction

    // work out the results of one input beat and update the mirrored table
    task automatic predict_beat(input logic act, input logic [31:0] per, input logic rpt,
                                input logic [7:0] tag);
        int            i;
        int            free_slot;
        int            fires;
        bit            have_prev;
        timer_result_t prev;
        free_slot = -1;
        fires     = 0;
        have_prev = 0;
        prev      = '0;
        if (act == ACT_REG)
        begin
            if (per != 32'd0 && tick_len != 16'd0 && (per % {16'd0, tick_len}) == 32'd0)
            begin
                for (i = 0; i < NUM_TIMERS; i++)
                begin
                    if (!live[i] && free_slot < 0)
                        free_slot = i;
                end
            end
            if (free_slot < 0)
            begin
                queue_result(make_result(KIND_REG, 1'b0, 4'd0, 8'd0, 1'b1));
            end
            else
            begin
                live[free_slot]       = 1'b1;
                count_ms[free_slot]   = per;
                reload_val[free_slot] = per;
                repeats[free_slot]    = rpt;
                tags[free_slot]       = tag;
                queue_result(make_result(KIND_REG, 1'b1, 4'(free_slot), 8'd0, 1'b1));
            end
        end
        else
        begin
            // walk in slot order; saturate at zero when the tick outgrows the count
            for (i = 0; i < NUM_TIMERS; i++)
            begin
                if (!live[i])
                    continue;
                if (count_ms[i] > {16'd0, tick_len})
                begin
                    count_ms[i] = count_ms[i] - {16'd0, tick_len};
                    continue;
                end
                if (tick_len == 16'd0)
                    continue;
                count_ms[i] = 32'd0;
                if (fires < MAX_OUT)
                begin
                    // hold each firing back one step so the final one can take last
                    if (have_prev)
                        queue_result(prev);
                    prev      = make_result(KIND_FIRE, 1'b0, 4'(i), tags[i], 1'b0);
                    have_prev = 1;
                    fires++;
                end
                if (repeats[i])
                    count_ms[i] = reload_val[i];
                else
                    live[i] = 1'b0;
            end
            if (have_prev)
            begin
                prev.last = 1'b1;
                queue_result(prev);
            end
            else
            begin
                queue_result(make_result(KIND_EMPTY, 1'b0, 4'd0, 8'd0, 1'b1));
            end
        end
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin : monitor
        timer_result_t want;
        int            k;
        if (!rst_n)
        begin
            tick_len = TICK_PERIOD_RST;
            for (k = 0; k < NUM_TIMERS; k++)
                live[k] = 1'b0;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_write)
                tick_len = cfg_data;
            if (in_valid && !in_stall)
                predict_beat(action, period_ms, repeat_mode, callback_tag);
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result beat with none expected (kind %0d slot %0d)",
                                              kind, slot));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (kind !== want.kind)
                        report_mismatch($sformatf("kind got %0d expected %0d", kind, want.kind));
                    if (accepted !== want.accepted)
                        report_mismatch($sformatf("accepted got %0d expected %0d",
                                                  accepted, want.accepted));
                    if (slot !== want.slot)
                        report_mismatch($sformatf("slot got %0d expected %0d", slot, want.slot));
                    if (fired_tag !== want.tag)
                        report_mismatch($sformatf("fired_tag got %0d expected %0d",
                                                  fired_tag, want.tag));
                    if (last !== want.last)
                        report_mismatch($sformatf("last got %0d expected %0d", last, want.last));
                end
            end
            pending <= expected_results.size();
        end
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - top of the software timer table testbench
// Drives directed and random register and tick beats in bursts across
// several tick periods, stalls the result side on its own pattern and
// reports the verdict from the checker's mismatch count.
// ---------------------------------------------------------------------------
module tb;
    import stt_pkg::*;

    localparam int LIMIT_CYCLES  = 600000;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_BEATS   = 16;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [31:0] period_ms;
    logic        repeat_mode;
    logic [7:0]  callback_tag;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic        accepted;
    logic [3:0]  slot;
    logic [7:0]  fired_tag;
    logic        last;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   burst_left  = 0;
    logic hold_go;

    software_timer_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .period_ms    (period_ms),
        .repeat_mode  (repeat_mode),
        .callback_tag (callback_tag),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .accepted     (accepted),
        .slot         (slot),
        .fired_tag    (fired_tag),
        .last         (last)
    );

    stt_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .period_ms    (period_ms),
        .repeat_mode  (repeat_mode),
        .callback_tag (callback_tag),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .accepted     (accepted),
        .slot         (slot),
        .fired_tag    (fired_tag),
        .last         (last),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("** software_timer_table: FAILED **");
            $finish;
        end
    end

    // offer one beat, opening a random gap when the current burst is used up
    task automatic send_beat(input logic act, input logic [31:0] per, input logic rpt,
                             input logic [7:0] tag);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        in_valid     <= 1'b1;
        action       <= act;
        period_ms    <= per;
        repeat_mode  <= rpt;
        callback_tag <= tag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
    endtask

    // stop offering, wait for every expected result, then let the block settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tick_period(input logic [15:0] value);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // result side: random stall stretches plus one long hold-off
    initial
    begin : receiver
        int seg_left;
        int mode;
        int hold_cnt;
        bit hold_done;
        seg_left  = 0;
        mode      = 0;
        hold_cnt  = 0;
        hold_done = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cnt > 0)
            begin
                out_stall <= 1'b1;
                hold_cnt--;
            end
            else if (hold_go && !hold_done)
            begin
                hold_done = 1;
                hold_cnt  = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 2);
                    seg_left = $urandom_range(20, 200);
                end
                seg_left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        logic [15:0] phase_ticks [NUM_PHASES];
        logic [15:0] tick_now;
        logic [31:0] per;
        logic        act;
        logic        rpt;
        logic [7:0]  tag;
        int          pick;
        int          mult;
        int          p;
        int          n;

        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_data     <= 16'd0;
        in_valid     <= 1'b0;
        action       <= ACT_TICK;
        period_ms    <= 32'd0;
        repeat_mode  <= 1'b0;
        callback_tag <= 8'd0;
        hold_go      <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset tick period of 200 ms
        send_beat(ACT_TICK, 32'd0, 1'b0, 8'd0);               // empty table
        send_beat(ACT_REG, 32'd0, 1'b0, 8'h11);               // zero period
        send_beat(ACT_REG, 32'd300, 1'b1, 8'h22);             // not a multiple
        send_beat(ACT_REG, 32'd200, 1'b0, 8'h00);             // one-shot, slot 0
        send_beat(ACT_REG, 32'd400, 1'b1, 8'hFF);             // repeat, slot 1
        send_beat(ACT_REG, 32'hFFFF_FFFF, 1'b1, 8'h33);       // max, not a multiple
        send_beat(ACT_REG, 32'd4294967200, 1'b1, 8'hA5);      // huge multiple, slot 2
        send_beat(ACT_TICK, 32'hFFFF_FFFF, 1'b1, 8'hFF);      // one-shot fires
        send_beat(ACT_TICK, 32'd0, 1'b0, 8'd0);               // repeat fires, reloads
        send_beat(ACT_REG, 32'd200, 1'b1, 8'h5A);             // reuses freed slot 0
        send_beat(ACT_TICK, 32'd0, 1'b0, 8'd0);
        send_beat(ACT_TICK, 32'd0, 1'b0, 8'd0);               // two fire together
        // fill the table, then one more is refused
        for (n = 3; n < NUM_TIMERS; n++)
            send_beat(ACT_REG, 32'd200, 1'b0, 8'(n * 17));
        send_beat(ACT_REG, 32'd200, 1'b0, 8'h77);
        send_beat(ACT_TICK, 32'd0, 1'b0, 8'd0);               // many firings in slot order

        // random phases over several tick periods, extremes and zero among them
        phase_ticks = '{16'd1, 16'd65535, 16'd0, 16'd7, 16'($urandom_range(2, 500)), 16'd200};
        for (p = 0; p < NUM_PHASES; p++)
        begin
            tick_now = phase_ticks[p];
            write_tick_period(tick_now);
            if (p == 0)
                hold_go <= 1'b1;
            for (n = 0; n < PHASE_BEATS; n++)
            begin
                pick = $urandom_range(0, 99);
                mult = $urandom_range(1, 4);
                per  = $urandom();
                rpt  = 1'($urandom_range(0, 1));
                tag  = 8'($urandom_range(0, 255));
                if (pick < 45)
                begin
                    act = ACT_TICK;
                end
                else
                begin
                    act = ACT_REG;
                    if (pick < 85)
                    begin
                        per = (tick_now == 16'd0) ? 32'(mult * 100)
                                                  : 32'(tick_now) * 32'(mult);
                        rpt = ($urandom_range(0, 99) < 15);
                    end
                    else
                    begin
                        case ($urandom_range(0, 4))
                            0:       per = 32'd0;
                            1:       per = 32'hFFFF_FFFF;
                            2:       per = 32'(tick_now) * 32'(mult) + 32'd1;
                            3:       per = 32'(tick_now) * 32'($urandom_range(1, 65537));
                            default: ;
                        endcase
                    end
                end
                send_beat(act, per, rpt, tag);
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("** software_timer_table: PASSED **");
        else
            $display("** software_timer_table: FAILED **");
        $finish;
    end

endmodule
